// File: sv/sensor_duty_cycle_recovery_sequencer_assert.svh
// assertion macros for the duty-cycle sequencer checker
`ifndef SENSOR_DUTY_CYCLE_RECOVERY_SEQUENCER_ASSERT_SVH
`define SENSOR_DUTY_CYCLE_RECOVERY_SEQUENCER_ASSERT_SVH

// clocked check, ignored while reset is asserted
`define SDCRS_ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also holds during reset
`define SDCRS_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: sv/sdcrs_pkg.sv
`timescale 1ns / 1ps

package sdcrs_pkg;

    // widths
    localparam int REG_W          = 20;
    localparam int TIME_WIDTH_DEF = 20;
    localparam int ADDR_W         = 5;
    localparam int DATA_W         = 32;

    // register indexes
    localparam logic [2:0] REG_SLEEP       = 3'd0;
    localparam logic [2:0] REG_STABILISE   = 3'd1;
    localparam logic [2:0] REG_WINDOW      = 3'd2;
    localparam logic [2:0] REG_TIER_ONE    = 3'd3;
    localparam logic [2:0] REG_TIER_TWO    = 3'd4;
    localparam logic [2:0] REG_TIER_THREE  = 3'd5;
    localparam logic [2:0] REG_PRESENT     = 3'd6;

    // register reset values
    localparam logic [REG_W-1:0] SLEEP_MS_RST      = 20'd90000;
    localparam logic [REG_W-1:0] STABILISE_MS_RST  = 20'd30000;
    localparam logic [REG_W-1:0] WINDOW_MS_RST     = 20'd12000;
    localparam logic [REG_W-1:0] TIER_ONE_MS_RST   = 20'd3000;
    localparam logic [REG_W-1:0] TIER_TWO_MS_RST   = 20'd6000;
    localparam logic [REG_W-1:0] TIER_THREE_MS_RST = 20'd9000;

    // recovery tier levels
    localparam logic [1:0] TIER_NONE   = 2'd0;
    localparam logic [1:0] TIER_FLUSH  = 2'd1;
    localparam logic [1:0] TIER_WAKE   = 2'd2;
    localparam logic [1:0] TIER_RELINK = 2'd3;

    typedef enum logic [1:0] {
        PH_ASLEEP  = 2'd0,
        PH_WARMING = 2'd1,
        PH_READING = 2'd2
    } phase_t;

    typedef struct packed {
        logic ms_tick;
        logic frame_ok;
    } poll_word_t;

    typedef struct packed {
        logic       send_wake;
        logic       send_sleep;
        logic       flush_rx;
        logic       reinit_link;
        logic       publish;
        logic       readings_stable;
        logic [1:0] phase_out;
        logic [1:0] tier_out;
    } result_word_t;

endpackage

// File: sv/sensor_duty_cycle_recovery_sequencer.sv
`timescale 1ns / 1ps
// Duty-cycle sequencer for a particle sensor: asleep, warming, reading.
// Poll channel (poll_valid/poll_ready/poll): one word per poll, carrying a
// millisecond tick and a frame-received flag. Result channel
// (result_valid/result_ready/result): exactly one word per poll with the
// command pulses, the stable flag, the phase and the recovery tier after it.
// Latency: the result word is valid the cycle after the poll is taken.
// Throughput: one poll per clock; the phase, counter and tier registers are
// updated in the same cycle the poll is taken, so the next poll can follow.
// A stalled result word sits in the output register; a new poll is taken
// only when that register is empty or being read in the same cycle, so a
// stalled receiver holds off the poll channel after one word.
// Reset (rst_n low, asynchronous): phase asleep, counter, tier and stable
// flag cleared, timing registers at their defaults, sensor marked absent,
// no result pending. Timing registers sit on an APB-style port at byte
// addresses 4*index; pready is always high and reads return the register.
module sensor_duty_cycle_recovery_sequencer #(
    parameter int TIME_WIDTH = sdcrs_pkg::TIME_WIDTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         poll_valid,
    output logic                         poll_ready,
    input  sdcrs_pkg::poll_word_t        poll,
    output logic                         result_valid,
    input  logic                         result_ready,
    output sdcrs_pkg::result_word_t      result,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [sdcrs_pkg::ADDR_W-1:0] paddr,
    input  logic [sdcrs_pkg::DATA_W-1:0] pwdata,
    output logic [sdcrs_pkg::DATA_W-1:0] prdata,
    output logic                         pready
);

    localparam int REG_W = sdcrs_pkg::REG_W;
    localparam int CMP_W = (TIME_WIDTH > REG_W) ? TIME_WIDTH : REG_W;
    localparam logic [TIME_WIDTH-1:0] TIME_TOP = {TIME_WIDTH{1'b1}};

    // configuration registers
    logic [REG_W-1:0] sleep_ms_reg, stabilise_ms_reg, window_ms_reg;
    logic [REG_W-1:0] tier_one_ms_reg, tier_two_ms_reg, tier_three_ms_reg;
    logic             present_reg;

    // sequencer state
    sdcrs_pkg::phase_t       phase_reg, phase_next;
    logic [TIME_WIDTH-1:0]   elapsed_reg, elapsed_next;
    logic [1:0]              tier_reg, tier_next;
    logic                    stable_reg, stable_next;

    // output register
    sdcrs_pkg::result_word_t result_reg, result_next;
    logic                    result_valid_reg, result_valid_next;

    logic                    accept;
    logic                    cfg_write;
    logic [2:0]              cfg_index;
    logic [TIME_WIDTH-1:0]   t_now;
    logic [CMP_W-1:0]        t_cmp;
    logic sleep_hit, stab_hit, window_hit, t1_hit, t2_hit, t3_hit, frame_take;
    logic wake_p, sleep_p, flush_p, relink_p, publish_p;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_index = paddr[sdcrs_pkg::ADDR_W-1:2];

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sleep_ms_reg      <= sdcrs_pkg::SLEEP_MS_RST;
            stabilise_ms_reg  <= sdcrs_pkg::STABILISE_MS_RST;
            window_ms_reg     <= sdcrs_pkg::WINDOW_MS_RST;
            tier_one_ms_reg   <= sdcrs_pkg::TIER_ONE_MS_RST;
            tier_two_ms_reg   <= sdcrs_pkg::TIER_TWO_MS_RST;
            tier_three_ms_reg <= sdcrs_pkg::TIER_THREE_MS_RST;
            present_reg       <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                sdcrs_pkg::REG_SLEEP:      sleep_ms_reg      <= pwdata[REG_W-1:0];
                sdcrs_pkg::REG_STABILISE:  stabilise_ms_reg  <= pwdata[REG_W-1:0];
                sdcrs_pkg::REG_WINDOW:     window_ms_reg     <= pwdata[REG_W-1:0];
                sdcrs_pkg::REG_TIER_ONE:   tier_one_ms_reg   <= pwdata[REG_W-1:0];
                sdcrs_pkg::REG_TIER_TWO:   tier_two_ms_reg   <= pwdata[REG_W-1:0];
                sdcrs_pkg::REG_TIER_THREE: tier_three_ms_reg <= pwdata[REG_W-1:0];
                sdcrs_pkg::REG_PRESENT:    present_reg       <= pwdata[0];
                default:                   ;
            endcase
        end
    end

    // register readback
    always_comb
    begin
        prdata = '0;
        case (cfg_index)
            sdcrs_pkg::REG_SLEEP:      prdata = 32'(sleep_ms_reg);
            sdcrs_pkg::REG_STABILISE:  prdata = 32'(stabilise_ms_reg);
            sdcrs_pkg::REG_WINDOW:     prdata = 32'(window_ms_reg);
            sdcrs_pkg::REG_TIER_ONE:   prdata = 32'(tier_one_ms_reg);
            sdcrs_pkg::REG_TIER_TWO:   prdata = 32'(tier_two_ms_reg);
            sdcrs_pkg::REG_TIER_THREE: prdata = 32'(tier_three_ms_reg);
            sdcrs_pkg::REG_PRESENT:    prdata = 32'(present_reg);
            default:                   prdata = '0;
        endcase
    end

    // handshake: take a poll when the output register is free or draining
    assign poll_ready = !result_valid_reg || result_ready;
    assign accept     = poll_valid && poll_ready;

    // saturating elapsed count including this poll's tick
    assign t_now = (poll.ms_tick && (elapsed_reg != TIME_TOP)) ?
                   elapsed_reg + 1'b1 : elapsed_reg;
    assign t_cmp = CMP_W'(t_now);

    // threshold compares
    assign sleep_hit  = t_cmp >= CMP_W'(sleep_ms_reg);
    assign stab_hit   = t_cmp >= CMP_W'(stabilise_ms_reg);
    assign window_hit = t_cmp >= CMP_W'(window_ms_reg);
    assign t1_hit     = (tier_reg < sdcrs_pkg::TIER_FLUSH)  && (t_cmp >= CMP_W'(tier_one_ms_reg));
    assign t2_hit     = (tier_reg < sdcrs_pkg::TIER_WAKE)   && (t_cmp >= CMP_W'(tier_two_ms_reg));
    assign t3_hit     = (tier_reg < sdcrs_pkg::TIER_RELINK) && (t_cmp >= CMP_W'(tier_three_ms_reg));
    assign frame_take = poll.frame_ok && present_reg && stable_reg;

    // next state
    always_comb
    begin
        phase_next  = phase_reg;
        tier_next   = tier_reg;
        stable_next = stable_reg;
        case (phase_reg)
            sdcrs_pkg::PH_ASLEEP:
            begin
                if (sleep_hit)
                begin
                    stable_next = 1'b0;
                    phase_next  = sdcrs_pkg::PH_WARMING;
                end
            end
            sdcrs_pkg::PH_WARMING:
            begin
                if (stab_hit)
                begin
                    stable_next = 1'b1;
                    tier_next   = sdcrs_pkg::TIER_NONE;
                    phase_next  = sdcrs_pkg::PH_READING;
                end
            end
            sdcrs_pkg::PH_READING:
            begin
                if (frame_take || window_hit)
                    phase_next = sdcrs_pkg::PH_ASLEEP;
                else if (t1_hit)
                    tier_next = sdcrs_pkg::TIER_FLUSH;
                else if (t2_hit)
                    tier_next = sdcrs_pkg::TIER_WAKE;
                else if (t3_hit)
                    tier_next = sdcrs_pkg::TIER_RELINK;
            end
            default:
                phase_next = sdcrs_pkg::PH_ASLEEP;
        endcase
        // counter restarts on any phase change
        elapsed_next = (phase_next != phase_reg) ? '0 : t_now;
    end

    // command pulses
    always_comb
    begin
        wake_p    = 1'b0;
        sleep_p   = 1'b0;
        flush_p   = 1'b0;
        relink_p  = 1'b0;
        publish_p = 1'b0;
        case (phase_reg)
            sdcrs_pkg::PH_ASLEEP:
                wake_p = sleep_hit && present_reg;
            sdcrs_pkg::PH_WARMING:
                flush_p = stab_hit;
            sdcrs_pkg::PH_READING:
            begin
                if (frame_take)
                begin
                    publish_p = 1'b1;
                    sleep_p   = present_reg;
                end
                else if (window_hit)
                    sleep_p = present_reg;
                else if (t1_hit)
                    flush_p = 1'b1;
                else if (t2_hit)
                    wake_p = present_reg;
                else if (t3_hit)
                    relink_p = 1'b1;
            end
            default:
                ;
        endcase
    end

    // result word and output valid
    always_comb
    begin
        result_next.send_wake       = wake_p;
        result_next.send_sleep      = sleep_p;
        result_next.flush_rx        = flush_p;
        result_next.reinit_link     = relink_p;
        result_next.publish         = publish_p;
        result_next.readings_stable = stable_next;
        result_next.phase_out       = phase_next;
        result_next.tier_out        = tier_next;
        if (accept)
            result_valid_next = 1'b1;
        else if (result_ready)
            result_valid_next = 1'b0;
        else
            result_valid_next = result_valid_reg;
    end

    // state and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= sdcrs_pkg::PH_ASLEEP;
            elapsed_reg      <= '0;
            tier_reg         <= sdcrs_pkg::TIER_NONE;
            stable_reg       <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
            if (accept)
            begin
                phase_reg   <= phase_next;
                elapsed_reg <= elapsed_next;
                tier_reg    <= tier_next;
                stable_reg  <= stable_next;
            end
        end
    end

    // output payload register
    always_ff @(posedge clk)
    begin
        if (accept)
            result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

// File: sv/sdcrs_checker.sv
`timescale 1ns / 1ps
`include "sensor_duty_cycle_recovery_sequencer_assert.svh"

module sdcrs_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         poll_valid,
    input logic                         poll_ready,
    input logic                         result_valid,
    input logic                         result_ready,
    input sdcrs_pkg::result_word_t      result,
    input logic                         pready
);

    // a stalled word holds
    `SDCRS_ASSERT_CLK(a_stall_hold,
        result_valid && !result_ready |=> result_valid && $stable(result),
        "result word changed while stalled")

    // a poll taken always yields a word on the next cycle
    `SDCRS_ASSERT_CLK(a_poll_result,
        poll_valid && poll_ready |=> result_valid,
        "taken poll produced no result word")

    // one command at most per poll
    `SDCRS_ASSERT_CLK(a_one_cmd,
        result_valid |-> $onehot0({result.send_wake, result.send_sleep,
                                   result.flush_rx, result.reinit_link}),
        "more than one command in a word")

    // publish always closes the window into sleep with stable readings
    `SDCRS_ASSERT_CLK(a_publish_sleep,
        result_valid && result.publish |->
            (result.phase_out == sdcrs_pkg::PH_ASLEEP) && result.readings_stable,
        "publish without return to asleep")

    // the bus never waits
    `SDCRS_ASSERT_ALWAYS(a_pready, pready, "pready dropped")

endmodule

bind sensor_duty_cycle_recovery_sequencer sdcrs_checker u_sdcrs_checker (.*);
